// ----- design/godd_pkg.sv -----
// ----------------------------------------------------------------------------
// godd_pkg: shared types and constants for the grid obstacle dilation block
// Field widths, register indexes, operation codes and cell flag layout.
// ----------------------------------------------------------------------------
`default_nettype none

package godd_pkg;

    // Fixed widths of the stream fields and configuration registers
    localparam int COORD_W     = 6;
    localparam int GRID_W      = 7;
    localparam int RADIUS_W    = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int S_DATA_W    = 16;
    localparam int S_USER_W    = 1;
    localparam int M_DATA_W    = 8;

    // Cell flag word
    localparam int FLAG_W           = 2;
    localparam int FLAG_PRESENT_BIT = 0;
    localparam int FLAG_WALK_BIT    = 1;

    // Default sizing
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_RADIUS = 8;

    // Register reset values
    localparam logic [GRID_W-1:0]   RST_GRID_COLS = 7'd64;
    localparam logic [GRID_W-1:0]   RST_GRID_ROWS = 7'd64;
    localparam logic [RADIUS_W-1:0] RST_RADIUS    = 4'd1;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_RADIUS = 2'd2;

    // Operation codes carried on tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

endpackage

`default_nettype wire

// ----- design/grid_obstacle_disk_dilation.sv -----
// ----------------------------------------------------------------------------
// grid_obstacle_disk_dilation: obstacle buffering over a cell grid
//
// The block keeps a grid of cells (present and walkable flag per cell) in one
// RAM. A write transfer (tuser = 0) stores one cell; a read transfer
// (tuser = 1) returns whether the cell is still walkable once obstacles are
// grown by a disk of radius buffer_radius. A seed is a present, non-walkable
// cell with a present, walkable 4-neighbour; a present, walkable cell reads
// invalid if a seed lies at a nonzero offset inside the disk. Every input
// transfer yields exactly one output transfer. Cells outside the configured
// grid count as absent. After reset a clearing pass sweeps the whole RAM
// with s_axis_tready low. A write or an out-of-range read goes from IDLE
// straight to PUSH. An in-range read goes through CENTER and then, when the
// cell is open and the radius nonzero, steps over the (2R+1)^2 square of
// offsets, reads each candidate inside the disk from the RAM, and reads the
// up to four in-grid neighbours of a candidate that is an obstacle; the
// scan stops at the first seed. This is bounded by the single read port of
// the cell RAM, one lookup in flight at a time. Items are worked one at a
// time; the output register lets the next item start while a result still
// waits on m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_obstacle_disk_dilation #(
    parameter int MAX_COLS   = godd_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = godd_pkg::DEF_MAX_ROWS,
    parameter int MAX_RADIUS = godd_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [godd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [godd_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: [5:0] cell_col, [11:6] cell_row, [12] cell_present,
    //        [13] cell_walkable, [15:14] zero
    input  wire logic [godd_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // tuser: [0] mode (0 write, 1 read)
    input  wire logic [godd_pkg::S_USER_W-1:0]      s_axis_tuser,

    // Output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: [0] cell_valid, [1] originally_walkable, [2] out_of_range,
    //        [7:3] zero
    output logic      [godd_pkg::M_DATA_W-1:0]      m_axis_tdata
);

    // ------------------------------------------------------------------
    // Sizing
    // ------------------------------------------------------------------
    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int AW     = CW + RW;
    localparam int DEPTH  = MAX_ROWS * (2 ** CW);
    localparam int XW_MIN = ((CW > RW) ? CW : RW) + 2;
    localparam int XW     = (XW_MIN > 9) ? XW_MIN : 9;    // signed coordinate
    localparam int OW     = godd_pkg::RADIUS_W + 2;        // signed offset
    localparam int GMAX   = (2 ** godd_pkg::GRID_W) - 1;
    localparam int RMAX   = (2 ** godd_pkg::RADIUS_W) - 1;
    localparam int EC     = (MAX_COLS > GMAX) ? GMAX : MAX_COLS;
    localparam int ER     = (MAX_ROWS > GMAX) ? GMAX : MAX_ROWS;
    localparam int ERAD   = (MAX_RADIUS > RMAX) ? RMAX : MAX_RADIUS;
    localparam int SQ_W   = 2 * godd_pkg::RADIUS_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTER,
        ST_CAND,
        ST_CHECK,
        ST_NEIGH,
        ST_PUSH
    } state_t;

    // which cell of the current candidate is being looked at
    typedef enum logic [2:0] {
        SUB_SELF,
        SUB_RIGHT,
        SUB_LEFT,
        SUB_DOWN,
        SUB_UP
    } sub_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                              state_reg;
    sub_t                                sub_reg;
    logic [AW-1:0]                       clr_addr_reg;
    logic [godd_pkg::GRID_W-1:0]         grid_cols_reg;
    logic [godd_pkg::GRID_W-1:0]         grid_rows_reg;
    logic [godd_pkg::RADIUS_W-1:0]       buffer_radius_reg;
    logic [godd_pkg::COORD_W-1:0]        col_reg;
    logic [godd_pkg::COORD_W-1:0]        row_reg;
    logic [godd_pkg::RADIUS_W-1:0]       rad_reg;
    logic [SQ_W-1:0]                     rad_sq_reg;
    logic signed [OW-1:0]                dx_reg;
    logic signed [OW-1:0]                dy_reg;
    logic                                res_valid_reg;
    logic                                res_ow_reg;
    logic                                res_oor_reg;
    logic                                m_valid_reg;
    logic [godd_pkg::M_DATA_W-1:0]       m_data_reg;

    // ------------------------------------------------------------------
    // Effective configuration (saturated to the build size)
    // ------------------------------------------------------------------
    logic [godd_pkg::GRID_W-1:0]   eff_cols;
    logic [godd_pkg::GRID_W-1:0]   eff_rows;
    logic [godd_pkg::RADIUS_W-1:0] eff_rad;

    assign eff_cols = (grid_cols_reg > godd_pkg::GRID_W'(EC)) ?
                      godd_pkg::GRID_W'(EC) : grid_cols_reg;
    assign eff_rows = (grid_rows_reg > godd_pkg::GRID_W'(ER)) ?
                      godd_pkg::GRID_W'(ER) : grid_rows_reg;
    assign eff_rad  = (buffer_radius_reg > godd_pkg::RADIUS_W'(ERAD)) ?
                      godd_pkg::RADIUS_W'(ERAD) : buffer_radius_reg;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                          in_xfer;
    logic                          in_mode;
    logic [godd_pkg::COORD_W-1:0]  in_col;
    logic [godd_pkg::COORD_W-1:0]  in_row;
    logic                          in_present;
    logic                          in_walk;
    logic                          in_inside;
    logic signed [XW-1:0]          in_x;
    logic signed [XW-1:0]          in_y;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_mode       = s_axis_tuser[0];
    assign in_col        = s_axis_tdata[5:0];
    assign in_row        = s_axis_tdata[11:6];
    assign in_present    = s_axis_tdata[12];
    assign in_walk       = s_axis_tdata[13];
    assign in_x          = $signed(XW'(in_col));
    assign in_y          = $signed(XW'(in_row));
    assign in_inside     = (in_x < $signed(XW'(eff_cols))) &&
                           (in_y < $signed(XW'(eff_rows)));

    // ------------------------------------------------------------------
    // Candidate and neighbour coordinates
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cand_x;
    logic signed [XW-1:0] cand_y;
    logic signed [XW-1:0] nb_x;
    logic signed [XW-1:0] nb_y;
    logic signed [1:0]    nb_ox;
    logic signed [1:0]    nb_oy;
    logic                 cand_in_grid;
    logic                 nb_in_grid;
    logic [SQ_W-1:0]      dx_sq;
    logic [SQ_W-1:0]      dy_sq;
    logic [SQ_W:0]        dist_sq;
    logic                 in_disk;
    logic                 zero_off;
    logic                 cand_ok;

    assign cand_x = $signed(XW'(col_reg)) + XW'(dx_reg);
    assign cand_y = $signed(XW'(row_reg)) + XW'(dy_reg);

    always_comb
    begin
        case (sub_reg)
            SUB_RIGHT: begin nb_ox = 2'sd1;  nb_oy = 2'sd0;  end
            SUB_LEFT:  begin nb_ox = -2'sd1; nb_oy = 2'sd0;  end
            SUB_DOWN:  begin nb_ox = 2'sd0;  nb_oy = 2'sd1;  end
            SUB_UP:    begin nb_ox = 2'sd0;  nb_oy = -2'sd1; end
            default:   begin nb_ox = 2'sd0;  nb_oy = 2'sd0;  end
        endcase
    end

    assign nb_x = cand_x + XW'(nb_ox);
    assign nb_y = cand_y + XW'(nb_oy);

    assign cand_in_grid = !cand_x[XW-1] && !cand_y[XW-1] &&
                          (cand_x < $signed(XW'(eff_cols))) &&
                          (cand_y < $signed(XW'(eff_rows)));
    assign nb_in_grid   = !nb_x[XW-1] && !nb_y[XW-1] &&
                          (nb_x < $signed(XW'(eff_cols))) &&
                          (nb_y < $signed(XW'(eff_rows)));

    // offsets are widened before squaring so the product keeps all its bits
    assign dx_sq    = $unsigned(SQ_W'(dx_reg) * SQ_W'(dx_reg));
    assign dy_sq    = $unsigned(SQ_W'(dy_reg) * SQ_W'(dy_reg));
    assign dist_sq  = (SQ_W + 1)'(dx_sq) + (SQ_W + 1)'(dy_sq);
    assign in_disk  = dist_sq <= (SQ_W + 1)'(rad_sq_reg);
    assign zero_off = (dx_reg == '0) && (dy_reg == '0);
    assign cand_ok  = !zero_off && in_disk && cand_in_grid;

    // Raster step over the (2R+1)^2 square
    logic signed [OW-1:0] pos_rad;
    logic signed [OW-1:0] neg_rad;
    logic signed [OW-1:0] dx_adv;
    logic signed [OW-1:0] dy_adv;
    logic                 scan_last;

    assign pos_rad   = $signed(OW'(rad_reg));
    assign neg_rad   = -pos_rad;
    assign scan_last = (dx_reg == pos_rad) && (dy_reg == pos_rad);
    assign dx_adv    = (dx_reg == pos_rad) ? neg_rad : dx_reg + OW'(1);
    assign dy_adv    = (dx_reg == pos_rad) ? dy_reg + OW'(1) : dy_reg;

    sub_t sub_adv;

    always_comb
    begin
        case (sub_reg)
            SUB_SELF:  sub_adv = SUB_RIGHT;
            SUB_RIGHT: sub_adv = SUB_LEFT;
            SUB_LEFT:  sub_adv = SUB_DOWN;
            SUB_DOWN:  sub_adv = SUB_UP;
            default:   sub_adv = SUB_UP;
        endcase
    end

    // ------------------------------------------------------------------
    // Cell RAM
    // ------------------------------------------------------------------
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [godd_pkg::FLAG_W-1:0] mem_wr_data;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [godd_pkg::FLAG_W-1:0] mem_rd_data;
    logic                        cell_open;
    logic                        cell_obstacle;
    logic                        write_xfer;
    logic                        read_xfer;

    assign write_xfer = in_xfer && (in_mode == godd_pkg::MODE_WRITE) && in_inside;
    assign read_xfer  = in_xfer && (in_mode == godd_pkg::MODE_READ) && in_inside;

    // Writes and reads never share a cycle, so no forwarding is needed.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = {in_y[RW-1:0], in_x[CW-1:0]};
        mem_wr_data = '0;
        mem_wr_data[godd_pkg::FLAG_PRESENT_BIT] = in_present;
        mem_wr_data[godd_pkg::FLAG_WALK_BIT]    = in_walk;
        mem_rd_en   = 1'b0;
        mem_rd_addr = {in_y[RW-1:0], in_x[CW-1:0]};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
            end
            ST_IDLE:
            begin
                mem_wr_en = write_xfer;
                mem_rd_en = read_xfer;
            end
            ST_CAND:
            begin
                mem_rd_en   = cand_ok;
                mem_rd_addr = {cand_y[RW-1:0], cand_x[CW-1:0]};
            end
            ST_NEIGH:
            begin
                mem_rd_en   = nb_in_grid;
                mem_rd_addr = {nb_y[RW-1:0], nb_x[CW-1:0]};
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    godd_ram #(
        .WIDTH (godd_pkg::FLAG_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign cell_open     = mem_rd_data[godd_pkg::FLAG_PRESENT_BIT] &&
                           mem_rd_data[godd_pkg::FLAG_WALK_BIT];
    assign cell_obstacle = mem_rd_data[godd_pkg::FLAG_PRESENT_BIT] &&
                           !mem_rd_data[godd_pkg::FLAG_WALK_BIT];

    // ------------------------------------------------------------------
    // Sequencer
    //   CLEAR  : sweep RAM to zero after reset
    //   IDLE   : take a transfer; writes go straight to the RAM
    //   CENTER : flags of the addressed cell are back
    //   CAND   : step over the square, read the next candidate in the disk
    //   CHECK  : evaluate the flags of the candidate or one of its neighbours
    //   NEIGH  : read the next in-grid neighbour of an obstacle candidate
    //   PUSH   : hand the result to the output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            sub_reg           <= SUB_SELF;
            clr_addr_reg      <= '0;
            grid_cols_reg     <= godd_pkg::RST_GRID_COLS;
            grid_rows_reg     <= godd_pkg::RST_GRID_ROWS;
            buffer_radius_reg <= godd_pkg::RST_RADIUS;
            col_reg           <= '0;
            row_reg           <= '0;
            rad_reg           <= '0;
            rad_sq_reg        <= '0;
            dx_reg            <= '0;
            dy_reg            <= '0;
            res_valid_reg     <= 1'b0;
            res_ow_reg        <= 1'b0;
            res_oor_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            m_data_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    godd_pkg::REG_GRID_COLS:
                        grid_cols_reg <= cfg_wdata;
                    godd_pkg::REG_GRID_ROWS:
                        grid_rows_reg <= cfg_wdata;
                    godd_pkg::REG_BUFFER_RADIUS:
                        buffer_radius_reg <= cfg_wdata[godd_pkg::RADIUS_W-1:0];
                    default:
                        ;
                endcase
            end

            // the push state reloads the output register itself
            if (m_valid_reg && m_axis_tready && state_reg != ST_PUSH)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        col_reg       <= in_col;
                        row_reg       <= in_row;
                        rad_reg       <= eff_rad;
                        rad_sq_reg    <= SQ_W'(eff_rad) * SQ_W'(eff_rad);
                        res_valid_reg <= 1'b0;
                        res_ow_reg    <= 1'b0;
                        res_oor_reg   <= !in_inside;
                        state_reg     <= read_xfer ? ST_CENTER : ST_PUSH;
                    end
                end

                ST_CENTER:
                begin
                    if (!cell_open)
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else if (rad_reg == '0)
                    begin
                        res_ow_reg    <= 1'b1;
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_PUSH;
                    end
                    else
                    begin
                        res_ow_reg <= 1'b1;
                        dx_reg     <= neg_rad;
                        dy_reg     <= neg_rad;
                        state_reg  <= ST_CAND;
                    end
                end

                ST_CAND:
                begin
                    if (cand_ok)
                    begin
                        sub_reg   <= SUB_SELF;
                        state_reg <= ST_CHECK;
                    end
                    else if (scan_last)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_PUSH;
                    end
                    else
                    begin
                        dx_reg <= dx_adv;
                        dy_reg <= dy_adv;
                    end
                end

                ST_CHECK:
                begin
                    if (sub_reg == SUB_SELF ? cell_obstacle : cell_open)
                    begin
                        // obstacle candidate: go look at its neighbours;
                        // open neighbour: candidate is a seed, cell invalid
                        if (sub_reg == SUB_SELF)
                        begin
                            sub_reg   <= sub_adv;
                            state_reg <= ST_NEIGH;
                        end
                        else
                        begin
                            state_reg <= ST_PUSH;
                        end
                    end
                    else if (sub_reg != SUB_SELF && sub_reg != SUB_UP)
                    begin
                        sub_reg   <= sub_adv;
                        state_reg <= ST_NEIGH;
                    end
                    else if (scan_last)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_PUSH;
                    end
                    else
                    begin
                        dx_reg    <= dx_adv;
                        dy_reg    <= dy_adv;
                        state_reg <= ST_CAND;
                    end
                end

                ST_NEIGH:
                begin
                    // off-grid neighbours count as absent and need no read
                    if (nb_in_grid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else if (sub_reg != SUB_UP)
                    begin
                        sub_reg <= sub_adv;
                    end
                    else if (scan_last)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_PUSH;
                    end
                    else
                    begin
                        dx_reg    <= dx_adv;
                        dy_reg    <= dy_adv;
                        state_reg <= ST_CAND;
                    end
                end

                ST_PUSH:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {5'b00000, res_oor_reg, res_ow_reg, res_valid_reg};
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTH
    // single RAM access per cycle: the sequencer never reads while writing
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("cell RAM read and write in the same cycle");

    // one item at a time: a transfer closes the input until its result is pushed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after a transfer");

    // a new result only leaves the push state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_PUSH))
        else $error("result produced outside the push state");
`endif

endmodule

`default_nettype wire

// ----- design/godd_ram.sv -----
// ----------------------------------------------------------------------------
// godd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module godd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- bench/tb_grid_obstacle_disk_dilation.sv -----
// ----------------------------------------------------------------------------
// tb_grid_obstacle_disk_dilation: self-checking bench for the obstacle buffer
// Cell writes and buffered-validity reads are streamed in with random gaps and
// output back-pressure. Every accepted transfer is run through a local model of
// the grid and the disk check, and each result transfer is compared against
// the oldest predicted verdict. Grid size and radius change between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_grid_obstacle_disk_dilation;

    localparam int MAP_COLS    = godd_pkg::DEF_MAX_COLS;
    localparam int MAP_ROWS    = godd_pkg::DEF_MAX_ROWS;
    localparam int MAP_RADIUS  = godd_pkg::DEF_MAX_RADIUS;
    // Watchdog limit on the whole run, in cycles.
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int TAIL_CYCLES = 64;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_wr_en     = 1'b0;
    logic [godd_pkg::CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [godd_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // tdata: [5:0] cell_col, [11:6] cell_row, [12] cell_present,
    //        [13] cell_walkable, [15:14] zero
    logic [godd_pkg::S_DATA_W-1:0]   s_axis_tdata  = '0;
    // tuser: [0] mode
    logic [godd_pkg::S_USER_W-1:0]   s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // tdata: [0] cell_valid, [1] originally_walkable, [2] out_of_range,
    //        [7:3] zero
    logic [godd_pkg::M_DATA_W-1:0]   m_axis_tdata;

    grid_obstacle_disk_dilation i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Grid model: mirror of the cell RAM and the three registers
    // ------------------------------------------------------------------------
    typedef struct {
        logic cell_valid;
        logic originally_walkable;
        logic out_of_range;
        int   col;
        int   row;
    } cell_verdict_t;

    logic [godd_pkg::FLAG_W-1:0]   cell_map [MAP_ROWS*MAP_COLS];
    logic [godd_pkg::GRID_W-1:0]   map_cols;
    logic [godd_pkg::GRID_W-1:0]   map_rows;
    logic [godd_pkg::RADIUS_W-1:0] map_radius;

    cell_verdict_t pending_verdicts [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    bit            no_idle        = 1'b0;  // both sides run flat out when set

    function automatic int cols_in_use();
        return (map_cols > MAP_COLS) ? MAP_COLS : int'(map_cols);
    endfunction

    function automatic int rows_in_use();
        return (map_rows > MAP_ROWS) ? MAP_ROWS : int'(map_rows);
    endfunction

    function automatic bit on_map(input int c, input int r);
        return c >= 0 && r >= 0 && c < cols_in_use() && r < rows_in_use();
    endfunction

    // Cells past the configured edge look absent, though the RAM keeps them.
    function automatic logic [godd_pkg::FLAG_W-1:0] flags_at(input int c, input int r);
        if (!on_map(c, r))
            return '0;
        return cell_map[r*MAP_COLS + c];
    endfunction

    function automatic bit open_at(input int c, input int r);
        logic [godd_pkg::FLAG_W-1:0] f;
        f = flags_at(c, r);
        return f[godd_pkg::FLAG_PRESENT_BIT] && f[godd_pkg::FLAG_WALK_BIT];
    endfunction

    // Boundary obstacle: present, not walkable, touching an open 4-neighbour.
    function automatic bit seed_at(input int c, input int r);
        logic [godd_pkg::FLAG_W-1:0] f;
        f = flags_at(c, r);
        if (!f[godd_pkg::FLAG_PRESENT_BIT] || f[godd_pkg::FLAG_WALK_BIT])
            return 1'b0;
        return open_at(c+1, r) || open_at(c-1, r) || open_at(c, r+1) || open_at(c, r-1);
    endfunction

    // Applies one accepted transfer to the map and returns the verdict it earns.
    function automatic cell_verdict_t predict_cell_verdict(input logic mode, input int c,
                                                           input int r, input logic present,
                                                           input logic walkable);
        cell_verdict_t v;
        int            rad;
        v.cell_valid          = 1'b0;
        v.originally_walkable = 1'b0;
        v.out_of_range        = !on_map(c, r);
        v.col                 = c;
        v.row                 = r;
        if (mode == godd_pkg::MODE_WRITE)
        begin
            if (on_map(c, r))
            begin
                cell_map[r*MAP_COLS + c][godd_pkg::FLAG_PRESENT_BIT] = present;
                cell_map[r*MAP_COLS + c][godd_pkg::FLAG_WALK_BIT]    = walkable;
            end
            return v;
        end
        if (on_map(c, r) && open_at(c, r))
        begin
            rad = (map_radius > MAP_RADIUS) ? MAP_RADIUS : int'(map_radius);
            v.originally_walkable = 1'b1;
            v.cell_valid          = 1'b1;
            for (int dy = -rad; dy <= rad; dy++)
            begin
                for (int dx = -rad; dx <= rad; dx++)
                begin
                    if ((dx != 0 || dy != 0) && dx*dx + dy*dy <= rad*rad &&
                        seed_at(c + dx, r + dy))
                        v.cell_valid = 1'b0;
                end
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------------
    function automatic int idle_cycles();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Called at a rising edge; returns at the edge where the transfer is taken.
    // tvalid stays high on return so back-to-back transfers need no toggle.
    task automatic push_cell(input logic mode, input int c, input int r,
                             input logic present, input logic walkable);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, walkable, present,
                          r[godd_pkg::COORD_W-1:0], c[godd_pkg::COORD_W-1:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_verdicts.push_back(predict_cell_verdict(mode, c, r, present, walkable));
    endtask

    // Sender goes quiet until every predicted verdict has come back.
    task automatic hold_until_settled();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Register writes only with the block idle; the map mirror follows each
    // write at the edge that captures it.
    task automatic set_grid(input logic [godd_pkg::CFG_DATA_W-1:0] cols,
                            input logic [godd_pkg::CFG_DATA_W-1:0] rows,
                            input logic [godd_pkg::CFG_DATA_W-1:0] radius);
        hold_until_settled();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= godd_pkg::REG_GRID_COLS;
        cfg_wdata <= cols;
        @(posedge clk);
        map_cols  = cols[godd_pkg::GRID_W-1:0];
        cfg_addr  <= godd_pkg::REG_GRID_ROWS;
        cfg_wdata <= rows;
        @(posedge clk);
        map_rows  = rows[godd_pkg::GRID_W-1:0];
        cfg_addr  <= godd_pkg::REG_BUFFER_RADIUS;
        cfg_wdata <= radius;
        @(posedge clk);
        map_radius = radius[godd_pkg::RADIUS_W-1:0];
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: alternating ready runs and stalls
    // ------------------------------------------------------------------------
    initial
    begin : drive_result_ready
        int   left;
        logic rdy;
        left = 0;
        rdy  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                rdy  = !rdy || no_idle;
                left = rdy ? $urandom_range(1, 30) : idle_cycles();
                m_axis_tready <= rdy;
            end
            else
                left--;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_verdicts
        cell_verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transfer 0x%0h with no verdict pending", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.cell_valid)
                begin
                    $error("cell (%0d,%0d) cell_valid: expected %0d, got %0d",
                           want.col, want.row, want.cell_valid, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[1] !== want.originally_walkable)
                begin
                    $error("cell (%0d,%0d) originally_walkable: expected %0d, got %0d",
                           want.col, want.row, want.originally_walkable, m_axis_tdata[1]);
                    mismatch_count++;
                end
                if (m_axis_tdata[2] !== want.out_of_range)
                begin
                    $error("cell (%0d,%0d) out_of_range: expected %0d, got %0d",
                           want.col, want.row, want.out_of_range, m_axis_tdata[2]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset clears the RAM: untouched cells, corners included, read absent.
    task automatic test_reset_state();
        push_cell(godd_pkg::MODE_READ, 0, 0, 1'b1, 1'b1);
        push_cell(godd_pkg::MODE_READ, 63, 63, 1'b0, 1'b0);
        push_cell(godd_pkg::MODE_READ, 63, 0, 1'b1, 1'b0);
    endtask

    // Seed formation and the radius-one disk at the reset settings.
    task automatic test_seed_and_disk();
        push_cell(godd_pkg::MODE_WRITE, 0, 0, 1'b1, 1'b1);
        push_cell(godd_pkg::MODE_READ, 0, 0, 1'b0, 1'b0);     // open, nothing near
        push_cell(godd_pkg::MODE_WRITE, 1, 0, 1'b1, 1'b0);    // obstacle next to open cell
        push_cell(godd_pkg::MODE_READ, 0, 0, 1'b0, 1'b0);     // now buffered out
        push_cell(godd_pkg::MODE_READ, 1, 0, 1'b0, 1'b0);     // obstacle itself
        push_cell(godd_pkg::MODE_WRITE, 63, 63, 1'b1, 1'b1);
        push_cell(godd_pkg::MODE_WRITE, 62, 63, 1'b0, 1'b1);  // walkable but not present
        push_cell(godd_pkg::MODE_READ, 63, 63, 1'b1, 1'b1);
        push_cell(godd_pkg::MODE_WRITE, 63, 62, 1'b1, 1'b0);
        push_cell(godd_pkg::MODE_READ, 63, 63, 1'b0, 1'b0);
        push_cell(godd_pkg::MODE_WRITE, 5, 2, 1'b1, 1'b1);
        push_cell(godd_pkg::MODE_WRITE, 6, 2, 1'b1, 1'b0);
    endtask

    // Shrunk grid: the seed at column 6 falls outside and stops counting;
    // writes and reads past the edge are flagged.
    task automatic test_grid_bounds();
        set_grid(7'd6, 7'd5, 7'd1);
        push_cell(godd_pkg::MODE_READ, 5, 2, 1'b0, 1'b0);
        push_cell(godd_pkg::MODE_WRITE, 6, 0, 1'b1, 1'b1);
        push_cell(godd_pkg::MODE_READ, 6, 0, 1'b0, 1'b0);
        push_cell(godd_pkg::MODE_READ, 0, 5, 1'b0, 1'b0);
        push_cell(godd_pkg::MODE_READ, 63, 63, 1'b1, 1'b1);
    endtask

    // Zero radius never buffers; radius two buffers out the cell beside the seed at column 6.
    task automatic test_radius_extremes();
        set_grid(7'd64, 7'd64, 7'd0);
        push_cell(godd_pkg::MODE_READ, 0, 0, 1'b0, 1'b0);
        set_grid(7'd64, 7'd64, 7'd2);
        push_cell(godd_pkg::MODE_READ, 5, 2, 1'b0, 1'b0);
    endtask

    // Random cell traffic, mostly inside a window around the grid edge so
    // that obstacles, open cells and seeds pile up; a few full-range coords.
    task automatic test_random_traffic(input logic [godd_pkg::CFG_DATA_W-1:0] cols,
                                       input logic [godd_pkg::CFG_DATA_W-1:0] rows,
                                       input logic [godd_pkg::CFG_DATA_W-1:0] radius,
                                       input int count, input bit steady,
                                       input int c_lo, input int c_hi,
                                       input int r_lo, input int r_hi);
        int   c;
        int   r;
        int   kind;
        logic mode;
        logic present;
        logic walkable;
        set_grid(cols, rows, radius);
        no_idle = steady;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                c = $urandom_range(0, MAP_COLS - 1);
                r = $urandom_range(0, MAP_ROWS - 1);
            end
            else
            begin
                c = $urandom_range(c_lo, c_hi);
                r = $urandom_range(r_lo, r_hi);
            end
            mode = ($urandom_range(0, 99) < 45) ? godd_pkg::MODE_READ : godd_pkg::MODE_WRITE;
            kind = $urandom_range(0, 9);
            if (mode == godd_pkg::MODE_READ)
            begin
                present  = 1'($urandom_range(0, 1));
                walkable = 1'($urandom_range(0, 1));
            end
            else if (kind < 5)
                {present, walkable} = 2'b11;   // open floor
            else if (kind < 8)
                {present, walkable} = 2'b10;   // obstacle
            else if (kind == 8)
                {present, walkable} = 2'b00;
            else
                {present, walkable} = 2'b01;
            if ($urandom_range(0, 199) == 0)
                hold_until_settled();
            push_cell(mode, c, r, present, walkable);
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (cell_map[i])
            cell_map[i] = '0;
        map_cols   = godd_pkg::RST_GRID_COLS;
        map_rows   = godd_pkg::RST_GRID_ROWS;
        map_radius = godd_pkg::RST_RADIUS;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_seed_and_disk();
        test_grid_bounds();
        test_radius_extremes();

        test_random_traffic(7'd8,   7'd8,   7'd1,  280, 1'b0, 0, 9, 0, 9);
        test_random_traffic(7'd12,  7'd9,   7'd2,  280, 1'b1, 0, 13, 0, 10);
        test_random_traffic(7'd16,  7'd16,  7'd3,  200, 1'b0, 0, 17, 0, 17);
        test_random_traffic(7'd1,   7'd1,   7'd0,   60, 1'b0, 0, 2, 0, 2);
        test_random_traffic(7'd127, 7'd0,   7'd4,   60, 1'b0, 0, 63, 0, 63);
        test_random_traffic(7'd64,  7'd100, 7'h7F, 150, 1'b0, 50, 63, 50, 63);
        test_random_traffic(7'd20,  7'd33,  7'd5,  250, 1'b0, 10, 21, 22, 34);
        test_random_traffic(7'd64,  7'd2,   7'd4,  150, 1'b0, 0, 20, 0, 3);
        test_random_traffic(7'd40,  7'd64,  7'd8,  100, 1'b0, 28, 41, 0, 12);
        test_random_traffic(7'd8,   7'd8,   7'd0,  100, 1'b0, 0, 9, 0, 9);

        hold_until_settled();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
